>>> rtl/fmp_pkg.sv
// fmp_pkg: shared types and constants for the feature map pooling block
// no dependencies
`default_nettype none
package fmp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = 20;
  localparam int SLOT_W      = 2;
  localparam int COL_W       = 4;
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int DEPTH       = 1 << ADDR_W;
  localparam int SLOTS       = 1 << SLOT_W;
  localparam int COLS        = 1 << COL_W;
  localparam int N_W         = 7;
  localparam int MAX_RESULTS = 64;
  localparam int PADDR_W     = 5;
  localparam int RECIP_SH    = 23;
  localparam logic [ACC_W-1:0] RECIP9 = 20'd932067;

  typedef enum logic [2:0] {
    REG_MODE, REG_KERNEL, REG_STRIDE, REG_PAD, REG_IH, REG_IW, REG_OH, REG_OW
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC_CHK, ST_ACC_WR, ST_EM_CHK, ST_EM_RD, ST_EM_MUL, ST_EM_OUT,
    ST_FLUSH, ST_FIN
  } state_t;

  typedef struct packed {
    logic [2:0] k;
    logic [2:0] s;
    logic [1:0] p;
    logic [6:0] ih;
    logic [6:0] iw;
    logic [4:0] oh;
    logic [4:0] ow;
  } geom_t;

  typedef struct packed {
    logic take;
    logic acc_rd;
    logic acc_wr;
    logic acc_next;
    logic em_start;
    logic em_rd;
    logic em_mul;
    logic em_push;
    logic em_drop;
    logic em_adv;
    logic flush_push;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic d_done;
    logic acc_hit;
    logic col_last;
    logic row_ready;
    logic w_last;
    logic n_full;
    logic hold_valid;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/feature_map_pooling.sv
// feature_map_pooling: streaming 2-d max / average pooling, top level
// per word: accept, then a scan over up to 4*out_width windows (min(4, rows left)
//   row slots), a read and a write per window update, a close of the scan and a finishing step
// at row end: a check per finished row, read, multiply and output per emitted window, a flush (held under stall)
// a new word is taken only once the last one is finished; the single accumulator ram port is shared
// synchronous active-low reset: default geometry, empty accumulators, counters at zero
// depends on fmp_pkg, fmp_cfg, fmp_ctrl, fmp_dp
`default_nettype none
module feature_map_pooling import fmp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input word channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  // result word channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SAMPLE_W-1:0]      out_pooled,
  output logic                     out_run_last,
  output logic                     out_plane_end,
  // register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  geom_t geom;
  logic  mode, cfg_clear;
  cmd_t  cmd;
  sts_t  sts;

  // registers, clamped geometry and a restart pulse on every write
  fmp_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .geom, .mode, .cfg_clear
  );

  // sequencer: scan slots, update windows, emit finished rows, mark the last result of each word
  fmp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .sts, .cmd
  );

  // accumulator ram with per-entry valid bits, counters, divider, output register
  fmp_dp u_dp (
    .clk, .rst_n, .geom, .mode, .cfg_clear, .in_sample, .cmd, .sts,
    .out_pooled, .out_run_last, .out_plane_end, .out_valid, .out_stall
  );

endmodule
`default_nettype wire

>>> rtl/fmp_cfg.sv
// fmp_cfg: register file behind the apb-style port, clamps the geometry
// depends on fmp_pkg
`default_nettype none
module fmp_cfg import fmp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output geom_t                   geom,
  output logic                    mode,
  output logic                    cfg_clear
);

  logic       mode_r;
  logic [2:0] k_r, s_r;
  logic [1:0] p_r;
  logic [6:0] ih_r, iw_r;
  logic [4:0] oh_r, ow_r;
  logic       wr;
  reg_idx_t   idx;

  assign pready    = 1'b1;
  assign wr        = psel & penable & pwrite;
  assign idx       = reg_idx_t'(paddr[4:2]);
  assign cfg_clear = wr;
  assign mode      = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; k_r <= 3'd2; s_r <= 3'd2; p_r <= 2'd0;
      ih_r <= 7'd28; iw_r <= 7'd28; oh_r <= 5'd14; ow_r <= 5'd14;
    end else if (wr) begin
      case (idx)
        REG_MODE:   mode_r <= pwdata[0];
        REG_KERNEL: k_r    <= pwdata[2:0];
        REG_STRIDE: s_r    <= pwdata[2:0];
        REG_PAD:    p_r    <= pwdata[1:0];
        REG_IH:     ih_r   <= pwdata[6:0];
        REG_IW:     iw_r   <= pwdata[6:0];
        REG_OH:     oh_r   <= pwdata[4:0];
        REG_OW:     ow_r   <= pwdata[4:0];
        default:    mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = {31'd0, mode_r};
      REG_KERNEL: prdata = {29'd0, k_r};
      REG_STRIDE: prdata = {29'd0, s_r};
      REG_PAD:    prdata = {30'd0, p_r};
      REG_IH:     prdata = {25'd0, ih_r};
      REG_IW:     prdata = {25'd0, iw_r};
      REG_OH:     prdata = {27'd0, oh_r};
      REG_OW:     prdata = {27'd0, ow_r};
      default:    prdata = 32'd0;
    endcase
  end

  // clamp into the used ranges
  always_comb begin
    geom.k  = (k_r == 3'd0) ? 3'd1 : ((k_r > 3'd4) ? 3'd4 : k_r);
    geom.s  = (s_r == 3'd0) ? 3'd1 : ((s_r > 3'd4) ? 3'd4 : s_r);
    geom.p  = p_r;
    geom.ih = (ih_r == 7'd0) ? 7'd1 : ((ih_r > 7'd64) ? 7'd64 : ih_r);
    geom.iw = (iw_r == 7'd0) ? 7'd1 : ((iw_r > 7'd64) ? 7'd64 : iw_r);
    geom.oh = (oh_r == 5'd0) ? 5'd1 : ((oh_r > 5'd16) ? 5'd16 : oh_r);
    geom.ow = (ow_r == 5'd0) ? 5'd1 : ((ow_r > 5'd16) ? 5'd16 : ow_r);
  end

endmodule
`default_nettype wire

>>> rtl/fmp_ctrl.sv
// fmp_ctrl: sequencer for accumulate, emit and flush of one word
// depends on fmp_pkg
`default_nettype none
module fmp_ctrl import fmp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  sts_t      sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_ACC_CHK;
      ST_ACC_CHK: begin
        if (sts.d_done)       state_nxt = sts.col_last ? ST_EM_CHK : ST_FIN;
        else if (sts.acc_hit) state_nxt = ST_ACC_WR;
      end
      ST_ACC_WR:  state_nxt = ST_ACC_CHK;
      ST_EM_CHK:  state_nxt = sts.row_ready ? ST_EM_RD : ST_FLUSH;
      ST_EM_RD:   state_nxt = ST_EM_MUL;
      ST_EM_MUL:  state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (sts.n_full || !sts.hold_valid || sts.out_free)
          state_nxt = sts.w_last ? ST_EM_CHK : ST_EM_RD;
      end
      ST_FLUSH: begin
        if (!sts.hold_valid || sts.out_free) state_nxt = ST_FIN;
      end
      ST_FIN:     state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_ACC_CHK: begin
        if (sts.d_done)       cmd.em_start = 1'b1;
        else if (sts.acc_hit) cmd.acc_rd   = 1'b1;
        else                  cmd.acc_next = 1'b1;
      end
      ST_ACC_WR: begin
        cmd.acc_wr   = 1'b1;
        cmd.acc_next = 1'b1;
      end
      ST_EM_RD:  cmd.em_rd  = 1'b1;
      ST_EM_MUL: cmd.em_mul = 1'b1;
      ST_EM_OUT: begin
        if (sts.n_full) begin
          cmd.em_drop = 1'b1;
          cmd.em_adv  = 1'b1;
        end else if (!sts.hold_valid || sts.out_free) begin
          cmd.em_push = 1'b1;
          cmd.em_adv  = 1'b1;
        end
      end
      ST_FLUSH:  cmd.flush_push = sts.hold_valid & sts.out_free;
      ST_FIN:    cmd.fin = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/fmp_dp.sv
// fmp_dp: window accumulator memory, position counters, divider and output stage
// depends on fmp_pkg
`default_nettype none
module fmp_dp import fmp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  geom_t                    geom,
  input  wire logic                mode,
  input  wire logic                cfg_clear,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic [SAMPLE_W-1:0]      out_pooled,
  output logic                     out_run_last,
  output logic                     out_plane_end,
  output logic                     out_valid,
  input  wire logic                out_stall
);

  logic [ACC_W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [ACC_W-1:0]  q_r;
  logic              vq_r;

  logic [5:0] row_r, col_r;
  logic [4:0] nor_r;
  logic [2:0] d_r;
  logic [COL_W-1:0] w_r;
  logic [N_W-1:0] n_r;
  logic dropped_r;
  logic signed [ACC_W-1:0] x_r;

  logic signed [ACC_W-1:0] v_r;
  logic [ACC_W-1:0] mag_r;
  logic [2*ACC_W-1:0] prod_r;
  logic neg_r, padded_r;

  logic hold_valid_r, hold_pe_r;
  logic [SAMPLE_W-1:0] hold_val_r;
  logic out_valid_r, run_last_r, plane_end_r;
  logic [SAMPLE_W-1:0] pooled_r;

  // geometry of the row slot under accumulation and of the row being emitted
  logic [5:0] o_acc;
  logic [8:0] os_acc, os_em, ws;
  logic signed [9:0] ys_acc, ye_acc, ys_em, ye_em, xs, xe, rr, cc, ihm1, iwm1, last_in;
  logic row_hit, col_hit, last_plane, w_last;
  logic [ADDR_W-1:0] addr;
  logic signed [ACC_W-1:0] start_v, old_v, new_v, em_v;
  logic [ACC_W-1:0] em_mag, q0, q9, qsel, rem;
  logic signed [ACC_W-1:0] avg_v;
  logic [SAMPLE_W-1:0] res_v;
  logic out_free, load_out;

  assign o_acc   = {1'b0, nor_r} + {3'b0, d_r};
  assign os_acc  = 9'(o_acc) * 9'(geom.s);
  assign os_em   = 9'(nor_r) * 9'(geom.s);
  assign ws      = 9'(w_r) * 9'(geom.s);
  assign ys_acc  = $signed({1'b0, os_acc}) - $signed({8'b0, geom.p});
  assign ye_acc  = ys_acc + $signed({7'b0, geom.k}) - 10'sd1;
  assign ys_em   = $signed({1'b0, os_em}) - $signed({8'b0, geom.p});
  assign ye_em   = ys_em + $signed({7'b0, geom.k}) - 10'sd1;
  assign xs      = $signed({1'b0, ws}) - $signed({8'b0, geom.p});
  assign xe      = xs + $signed({7'b0, geom.k}) - 10'sd1;
  assign rr      = $signed({4'b0, row_r});
  assign cc      = $signed({4'b0, col_r});
  assign ihm1    = $signed({3'b0, geom.ih}) - 10'sd1;
  assign iwm1    = $signed({3'b0, geom.iw}) - 10'sd1;
  assign last_in = (ye_em < ihm1) ? ye_em : ihm1;

  assign row_hit    = (rr >= ys_acc) && (rr <= ye_acc);
  assign col_hit    = (cc >= xs) && (cc <= xe);
  assign last_plane = (rr == ihm1) && (cc == iwm1);
  assign w_last     = ({1'b0, w_r} == (geom.ow - 5'd1));

  assign sts.d_done     = (d_r == 3'(SLOTS)) || (o_acc >= {1'b0, geom.oh});
  assign sts.acc_hit    = row_hit && col_hit;
  assign sts.col_last   = (cc == iwm1);
  assign sts.row_ready  = (nor_r < geom.oh) && (last_plane || (last_in <= rr));
  assign sts.w_last     = w_last;
  assign sts.n_full     = (n_r == N_W'(MAX_RESULTS));
  assign sts.hold_valid = hold_valid_r;
  assign sts.out_free   = out_free;

  assign addr    = cmd.em_rd ? {nor_r[SLOT_W-1:0], w_r} : {o_acc[SLOT_W-1:0], w_r};
  assign start_v = mode ? '0 : -(ACC_W'(1) << (SAMPLE_W - 1));
  assign old_v   = vq_r ? $signed(q_r) : start_v;
  assign new_v   = mode ? (old_v + x_r) : ((x_r > old_v) ? x_r : old_v);
  assign em_v    = old_v;
  assign em_mag  = (em_v < 0) ? ACC_W'(-em_v) : ACC_W'(em_v);

  always_ff @(posedge clk) begin
    if (cmd.acc_wr) mem[addr] <= new_v;
    if (cmd.acc_rd || cmd.em_rd) q_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vq_r  <= 1'b0;
    end else begin
      if (cmd.acc_rd || cmd.em_rd) vq_r <= vld_r[addr];
      if (cfg_clear || (cmd.fin && sts.col_last && (rr == ihm1))) begin
        vld_r <= '0;
      end else if (cmd.em_adv && w_last) begin
        vld_r[{nor_r[SLOT_W-1:0], {COL_W{1'b0}}} +: COLS] <= '0;
      end else if (cmd.acc_wr) begin
        vld_r[addr] <= 1'b1;
      end
    end
  end

  // k*k divide: shifts for k=2,4; k=3 reciprocal multiply, one correction step
  assign q0  = ACC_W'(prod_r >> RECIP_SH);
  assign rem = mag_r - ((q0 << 3) + q0);
  assign q9  = (rem >= ACC_W'(9)) ? q0 + ACC_W'(1) : q0;
  always_comb begin
    case (geom.k)
      3'd2:    qsel = mag_r >> 2;
      3'd3:    qsel = q9;
      3'd4:    qsel = mag_r >> 4;
      default: qsel = mag_r;
    endcase
  end
  assign avg_v = neg_r ? -$signed(qsel) : $signed(qsel);
  assign res_v = mode ? avg_v[SAMPLE_W-1:0]
                      : ((padded_r && v_r < 0) ? '0 : v_r[SAMPLE_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.em_mul) begin
      v_r      <= em_v;
      neg_r    <= (em_v < 0);
      mag_r    <= em_mag;
      prod_r   <= em_mag * RECIP9;
      padded_r <= (ys_em < 0) || (ye_em > ihm1) || (xs < 0) || (xe > iwm1);
    end
    if (cmd.take) x_r <= ACC_W'($signed(in_sample));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0; col_r <= '0; nor_r <= '0; d_r <= '0; w_r <= '0;
      n_r <= '0; dropped_r <= 1'b0;
    end else if (cfg_clear) begin
      row_r <= '0; col_r <= '0; nor_r <= '0; d_r <= '0; w_r <= '0;
    end else begin
      if (cmd.take) begin
        d_r <= '0; w_r <= '0; n_r <= '0; dropped_r <= 1'b0;
      end
      if (cmd.acc_next) begin
        if (w_last) begin
          w_r <= '0;
          d_r <= d_r + 3'd1;
        end else begin
          w_r <= w_r + COL_W'(1);
        end
      end
      if (cmd.em_start) w_r <= '0;
      if (cmd.em_push) n_r <= n_r + N_W'(1);
      if (cmd.em_drop) dropped_r <= 1'b1;
      if (cmd.em_adv) begin
        if (w_last) begin
          w_r   <= '0;
          nor_r <= nor_r + 5'd1;
        end else begin
          w_r <= w_r + COL_W'(1);
        end
      end
      if (cmd.fin) begin
        if (sts.col_last) begin
          col_r <= '0;
          if (rr == ihm1) begin
            row_r <= '0;
            nor_r <= '0;
          end else begin
            row_r <= row_r + 6'd1;
          end
        end else begin
          col_r <= col_r + 6'd1;
        end
      end
    end
  end

  // one-deep hold so the last result of a word can be marked
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (cmd.em_push && hold_valid_r) || cmd.flush_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.em_push) begin
        hold_valid_r <= 1'b1;
        hold_val_r   <= res_v;
        hold_pe_r    <= (nor_r == geom.oh - 5'd1) && w_last;
      end else if (cmd.flush_push || cmd.take) begin
        hold_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        pooled_r    <= hold_val_r;
        run_last_r  <= cmd.flush_push;
        plane_end_r <= hold_pe_r | (cmd.flush_push & dropped_r & last_plane);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pooled    = pooled_r;
  assign out_run_last  = run_last_r;
  assign out_plane_end = plane_end_r;

endmodule
`default_nettype wire
